### design/signed_int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_int_to_decimal_ascii
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// cond at one edge implies prop at the next edge; quiet while in reset
`define ITOA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: next-cycle check failed");

// cond at one edge implies prop at the same edge; quiet while in reset
`define ITOA_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: same-cycle check failed");

`endif

### design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = 4;   // holds 0..MAX_DIGITS
  localparam int unsigned QUOT_W     = 29;  // (2^32 - 1) / 10 fits in 29 bits

  // ASCII codes, truncated to the character width
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // Divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture sign and magnitude of a new word
    logic mul;    // register the quotient of magnitude by ten
    logic dig;    // store one digit, replace magnitude by quotient
    logic emit;   // present and drop the most significant stored digit
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic q_zero;      // quotient is zero: this was the last digit
    logic neg;         // word is negative, a sign goes first
    logic last_digit;  // one stored digit remains
  } sts_t;

endpackage

### design/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude, divide-by-ten step, digit store and character output.
// ----------------------------------------------------------------------------
module itoa_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  itoa_pkg::cmd_t                         cmd,
  input  logic signed [itoa_pkg::VALUE_W-1:0]    value,
  output itoa_pkg::sts_t                         sts,
  output logic        [itoa_pkg::CHAR_W-1:0]     digit_char
);

  logic [itoa_pkg::VALUE_W-1:0]   mag;
  logic [itoa_pkg::QUOT_W-1:0]    quot;
  logic                           neg;
  logic [itoa_pkg::CNT_W-1:0]     ndig;
  logic [itoa_pkg::DIGIT_W-1:0]   digits [itoa_pkg::MAX_DIGITS];

  logic [2*itoa_pkg::VALUE_W-1:0] prod;
  logic [itoa_pkg::VALUE_W-1:0]   quot_ext;
  logic [itoa_pkg::VALUE_W-1:0]   quot_x10;
  logic [itoa_pkg::VALUE_W-1:0]   rem_full;
  logic [itoa_pkg::CNT_W-1:0]     rd_idx;

  // Reciprocal multiply; register the quotient before using it
  assign prod     = {{itoa_pkg::VALUE_W{1'b0}}, mag} *
                    {{itoa_pkg::VALUE_W{1'b0}}, itoa_pkg::RECIP_TEN};
  assign quot_ext = {{(itoa_pkg::VALUE_W-itoa_pkg::QUOT_W){1'b0}}, quot};
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem_full = mag - quot_x10;
  assign rd_idx   = ndig - itoa_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[itoa_pkg::VALUE_W-1];
      mag <= value[itoa_pkg::VALUE_W-1] ? (32'd0 - unsigned'(value)) : unsigned'(value);
    end
    if (cmd.mul) begin
      quot <= prod[itoa_pkg::RECIP_SHIFT +: itoa_pkg::QUOT_W];
    end
    if (cmd.dig) begin
      digits[ndig] <= rem_full[itoa_pkg::DIGIT_W-1:0];
      mag          <= quot_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ndig <= '0;
    end else if (cmd.load) begin
      ndig <= '0;
    end else if (cmd.dig) begin
      ndig <= ndig + itoa_pkg::CNT_W'(1);
    end else if (cmd.emit) begin
      ndig <= rd_idx;
    end
  end

  assign digit_char     = itoa_pkg::CHAR_ZERO +
                          {{(itoa_pkg::CHAR_W-itoa_pkg::DIGIT_W){1'b0}}, digits[rd_idx]};
  assign sts.q_zero     = (quot == '0);
  assign sts.neg        = neg;
  assign sts.last_digit = (ndig == itoa_pkg::CNT_W'(1));

endmodule

### design/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences the digit loop, the sign and the digit output.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           strobe,
  output logic           sel_sign,
  output logic           last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIG  = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIG;
      end
      S_DIG: begin
        cmd.dig = 1'b1;
        if (!sts.q_zero) begin
          state_next = S_MUL;
        end else if (sts.neg) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.last_digit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign sel_sign = (state == S_SIGN);
  assign strobe   = (state == S_SIGN) || (state == S_EMIT);
  assign last     = (state == S_EMIT) && sts.last_digit;

endmodule

### design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit word to its decimal text, one ASCII character
// per output word, most significant first, with a leading '-' if negative.
// ----------------------------------------------------------------------------
//
//   channel  | handshake          | payload          | notes
//   ---------+--------------------+------------------+-------------------------
//   input    | start, busy        | value[31:0] s    | taken when start & !busy
//   output   | strobe             | character[5:0],  | words back to back,
//            |                    | last             | receiver cannot stall
//
// Each digit takes a divide-by-ten step (reciprocal multiply, then
// remainder), least significant digit first; then come the sign word
// for a negative value and one output word per stored digit.
// busy is high from the cycle after acceptance until after the last word.
// Reset (rst, synchronous) returns the controller to idle; digit storage
// needs no clearing.
//
module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [itoa_pkg::VALUE_W-1:0] value,
  output logic                                strobe,
  output logic        [itoa_pkg::CHAR_W-1:0]  character,
  output logic                                last
);

  itoa_pkg::cmd_t               cmd;
  itoa_pkg::sts_t               sts;
  logic                         sel_sign;
  logic [itoa_pkg::CHAR_W-1:0]  digit_char;

  // Sequence the conversion: digit loop, optional sign, then digits out
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .strobe   (strobe),
    .sel_sign (sel_sign),
    .last     (last)
  );

  // Hold magnitude and digits, divide by ten, form the digit character
  itoa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .sts        (sts),
    .digit_char (digit_char)
  );

  // Drive the sign in its own cycle, the stored digit otherwise
  assign character = sel_sign ? itoa_pkg::CHAR_MINUS : digit_char;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

  // An accepted word starts the digit loop, never an output word
  `ITOA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe)
  // Output words run without gaps until the last one
  `ITOA_ASSERT_NEXT(a_no_gap, strobe && !last, strobe)
  // The last word ends the number and frees the block
  `ITOA_ASSERT_NEXT(a_last_ends, strobe && last, !strobe && !busy)
  // The sign is never the final character
  `ITOA_ASSERT_NOW(a_sign_not_last, strobe && (character == itoa_pkg::CHAR_MINUS), !last)

endmodule
